>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, active-low reset disables
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// condition that must hold on every rising edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion lbl failed");

`endif

>>> rtl/bhr_pkg.sv
// ----------------------------------------------------------------------------
// bhr_pkg
// shared types and constants of the banded histogram
// ----------------------------------------------------------------------------
`default_nettype none

package bhr_pkg;

  localparam int NUM_BINS    = 8;
  localparam int COUNT_WIDTH = 20;
  localparam int NUM_EDGES   = 8;
  localparam int EDGE_W      = 16;
  localparam int IDX_W       = 3;
  localparam int IDXX_W      = IDX_W + 1;
  localparam int BIN_W       = 4;
  localparam int OUT_COUNT_W = 20;
  localparam int OCC_W       = 3;
  localparam int ADDR_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int REG_IDX_W   = $clog2(NUM_EDGES);
  localparam int CFG_ADDR_W  = REG_IDX_W + 2;
  localparam int CFG_DATA_W  = 32;
  localparam int OP_W        = 2;

  localparam logic [EDGE_W-1:0] EDGE_RESET = 16'h7FFF;

  typedef logic [EDGE_W-1:0] edge_t;
  typedef edge_t [NUM_EDGES-1:0] edge_arr_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [OP_W-1:0] {
    OP_COUNT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_RANGE = 2'd3
  } op_t;

  // item held in the read-modify-write stage
  typedef struct packed {
    op_t               op;
    logic [BIN_W-1:0]  bin;
    logic [ADDR_W-1:0] addr;
    logic              counted;
    logic              idx_ok;
  } rmw_item_t;

  // one result item
  typedef struct packed {
    logic              all_empty;
    logic [OCC_W-1:0]  last_occupied;
    logic [OCC_W-1:0]  first_occupied;
    logic [OUT_COUNT_W-1:0] count;
    logic [BIN_W-1:0]  bin;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/banded_histogram_with_range.sv
// ----------------------------------------------------------------------------
// banded_histogram_with_range
// histogram with programmable upper bin edges, counters kept in a ram
// ----------------------------------------------------------------------------
// channel  | dir | handshake          | payload
// in       | in  | in_tvalid/tready   | tdata: sample, bin_index; tuser: operation
// out      | out | out_tvalid/tready  | tdata: bin, count, first, last, all_empty
// cfg      | in  | apb psel/penable   | edge_0 .. edge_7 at byte address 4*i
//
// one item per cycle unless the output stalls; a result is offered from the output
// register after the rmw stage (compare and ram read at the transfer edge, then
// read-modify-write into it). one counter read and one write per cycle set the rate; a
// write forwarded to the next read of the same bin keeps back-to-back counting exact.
// reset clears per-bin valid and occupied flags at once, no clearing pass.
// a stalled output holds the rmw stage; input stalls only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module banded_histogram_with_range
  import bhr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [23:0]           in_tdata,   // sample[15:0], bin_index[18:16]
  input  wire logic [OP_W-1:0]       in_tuser,   // operation[1:0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [31:0]                out_tdata,  // bin[3:0], count[23:4],
                                                 // first_occupied[26:24],
                                                 // last_occupied[29:27], all_empty[30]
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam count_t COUNT_MAX = '1;

  edge_arr_t          edges;
  logic               in_acc;
  op_t                in_op;
  logic [EDGE_W-1:0]  in_sample;
  logic [IDX_W-1:0]   in_idx;
  logic [BIN_W-1:0]   cls_bin;
  rmw_item_t          item_in;

  logic               s1_vld_r;
  rmw_item_t          s1_r;
  logic               s1_adv;
  logic               hit_r;
  count_t             fwd_r;
  count_t             rdata;
  count_t             cur;
  count_t             inc;
  logic               we;
  logic [NUM_BINS-1:0] valid_r;
  logic [NUM_BINS-1:0] occ_r;
  result_t            res;
  result_t            out_r;
  logic               out_vld_r;
  logic [OCC_W-1:0]   first_c;
  logic [OCC_W-1:0]   last_c;

  bhr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .edges   (edges)
  );

  // stage 0: classify and issue the counter read
  assign in_sample = in_tdata[EDGE_W-1:0];
  assign in_idx    = in_tdata[EDGE_W+IDX_W-1:EDGE_W];
  assign in_op     = op_t'(in_tuser);

  bhr_classify u_cls (
    .sample (in_sample),
    .edges  (edges),
    .bin    (cls_bin)
  );

  always_comb begin
    item_in.op      = in_op;
    item_in.counted = (in_op == OP_COUNT) && (cls_bin != BIN_W'(NUM_BINS));
    item_in.idx_ok  = {1'b0, in_idx} < IDXX_W'(NUM_BINS);
    if (in_op == OP_COUNT) begin
      item_in.bin  = cls_bin;
      item_in.addr = cls_bin[ADDR_W-1:0];
    end else begin
      item_in.bin  = BIN_W'(in_idx);
      item_in.addr = in_idx[ADDR_W-1:0];
    end
  end

  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  bhr_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (s1_r.addr),
    .wdata   (inc),
    .re      (in_acc),
    .raddr   (item_in.addr),
    .rdata_r (rdata)
  );

  // stage 1: read-modify-write; forwarded value covers a write at the read edge
  always_comb begin
    if (hit_r) begin
      cur = fwd_r;
    end else if (valid_r[s1_r.addr]) begin
      cur = rdata;
    end else begin
      cur = '0;
    end
    inc = (cur == COUNT_MAX) ? cur : cur + count_t'(1);
    we  = s1_adv && s1_r.counted;
  end

  always_comb begin
    first_c = '0;
    last_c  = OCC_W'(NUM_BINS - 1);
    for (int i = NUM_BINS - 1; i >= 0; i--) begin
      if (occ_r[i]) begin
        first_c = OCC_W'(i);
      end
    end
    for (int i = 0; i < NUM_BINS; i++) begin
      if (occ_r[i]) begin
        last_c = OCC_W'(i);
      end
    end
  end

  always_comb begin
    res = '0;
    unique case (s1_r.op)
      OP_COUNT: begin
        res.bin = s1_r.bin;
        if (s1_r.counted) begin
          res.count = OUT_COUNT_W'(inc);
        end
      end
      OP_READ: begin
        res.bin = s1_r.bin;
        if (s1_r.idx_ok) begin
          res.count = OUT_COUNT_W'(cur);
        end
      end
      OP_CLEAR: begin
        res = '0;
      end
      OP_RANGE: begin
        res.first_occupied = first_c;
        res.last_occupied  = last_c;
        res.all_empty      = (occ_r == '0);
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      hit_r     <= 1'b0;
      valid_r   <= '0;
      occ_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
        hit_r    <= we && (s1_r.addr == item_in.addr);
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
        hit_r    <= 1'b0;
      end
      if (s1_adv && (s1_r.op == OP_CLEAR)) begin
        valid_r <= '0;
        occ_r   <= '0;
      end else if (we) begin
        valid_r[s1_r.addr] <= 1'b1;
        occ_r[s1_r.addr]   <= 1'b1;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r  <= item_in;
      fwd_r <= inc;
    end
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = 32'(out_r);

  `ASSERT_IMP(a_ready_when_out_free, clk, rst_n, !out_vld_r, in_tready)
  `ASSERT_IMP(a_write_nonzero, clk, rst_n, we, inc != '0)
  `ASSERT_ALWAYS(a_valid_implies_occ, clk, rst_n, (valid_r & ~occ_r) == '0)
  `ASSERT_IMP(a_hit_needs_item, clk, rst_n, hit_r, s1_vld_r)

endmodule

`default_nettype wire

>>> rtl/bhr_ram.sv
// ----------------------------------------------------------------------------
// bhr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bhr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/bhr_cfg.sv
// ----------------------------------------------------------------------------
// bhr_cfg
// apb register file holding the upper bin edges
// ----------------------------------------------------------------------------
`default_nettype none

module bhr_cfg
  import bhr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output edge_arr_t                  edges
);

  edge_arr_t             edge_r;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_EDGES; i++) begin
        edge_r[i] <= EDGE_RESET;
      end
    end else if (wr_en) begin
      edge_r[reg_idx] <= pwdata[EDGE_W-1:0];
    end
  end

  // read back sign extended
  assign prdata = CFG_DATA_W'($signed(edge_r[reg_idx]));
  assign edges  = edge_r;

endmodule

`default_nettype wire

>>> rtl/bhr_classify.sv
// ----------------------------------------------------------------------------
// bhr_classify
// parallel edge compare picking the lowest bin whose edge covers the sample
// ----------------------------------------------------------------------------
`default_nettype none

module bhr_classify
  import bhr_pkg::*;
(
  input  wire logic [EDGE_W-1:0] sample,
  input  wire edge_arr_t         edges,
  output logic      [BIN_W-1:0]  bin
);

  logic [NUM_BINS-1:0] hit;

  always_comb begin
    for (int i = 0; i < NUM_BINS; i++) begin
      hit[i] = $signed(sample) <= $signed(edges[i]);
    end
    // above every edge reports one past the last bin
    bin = BIN_W'(NUM_BINS);
    for (int i = NUM_BINS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        bin = BIN_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// self-checking bench for the banded histogram with occupied-range report
// ----------------------------------------------------------------------------
// a cycle-free model of the bin edges and counters predicts every result.
// directed tests cover reset state, edge corner cases and a single-bin burst.
// random tests sweep several edge settings with idling on both streams,
// a long output hold-off and a full drain pause.
// ============================================================================

module tb_top
  import bhr_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 100;
  localparam int BURST_LEN      = 100;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata    = '0;   // sample[15:0], bin_index[18:16]
  logic [OP_W-1:0]       in_tuser    = '0;   // operation[1:0]
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [31:0]           out_tdata;          // bin[3:0], count[23:4], first[26:24],
                                             // last[29:27], all_empty[30]
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  banded_histogram_with_range u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // histogram model
  logic signed [EDGE_W-1:0] edge_model [NUM_EDGES];
  count_t                   bin_tally  [NUM_BINS];
  result_t                  pending_results [$];

  int  items_sent    = 0;
  int  results_seen  = 0;
  int  edge_settings = 0;
  int  fail_count    = 0;
  bit  src_idle_on   = 1'b1;
  bit  sink_idle_on  = 1'b1;
  int  hold_req_cnt  = 0;
  int  hold_ack_cnt  = 0;
  int  hold_left     = 0;
  int  quiet_cycles  = 0;

  result_t chk_want;
  result_t chk_got;

  function automatic result_t predict_result(op_t op, logic signed [EDGE_W-1:0] sample,
                                             logic [IDX_W-1:0] idx);
    result_t r;
    logic    found;
    int      i;
    r = '0;
    found = 1'b0;
    case (op)
      OP_COUNT: begin
        r.bin = BIN_W'(NUM_BINS);
        // walk down so the lowest matching bin is left in place
        for (i = NUM_BINS - 1; i >= 0; i--)
          if (sample <= edge_model[i]) r.bin = BIN_W'(i);
        if (r.bin < NUM_BINS) begin
          if (bin_tally[r.bin] != '1) bin_tally[r.bin] = bin_tally[r.bin] + 1'b1;
          r.count = OUT_COUNT_W'(bin_tally[r.bin]);
        end
      end
      OP_READ: begin
        r.bin = BIN_W'(idx);
        if (idx < NUM_BINS) r.count = OUT_COUNT_W'(bin_tally[idx]);
      end
      OP_CLEAR: begin
        for (i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;
      end
      default: begin
        r.first_occupied = '0;
        r.last_occupied  = OCC_W'(NUM_BINS - 1);
        for (i = NUM_BINS - 1; i >= 0; i--)
          if (bin_tally[i] != '0) begin
            r.first_occupied = OCC_W'(i);
            found = 1'b1;
          end
        for (i = 0; i < NUM_BINS; i++)
          if (bin_tally[i] != '0) r.last_occupied = OCC_W'(i);
        r.all_empty = !found;
      end
    endcase
    return r;
  endfunction

  task automatic send_item(input op_t op, input logic [EDGE_W-1:0] sample,
                           input logic [IDX_W-1:0] idx);
    result_t predicted;
    if (src_idle_on)
      while ($urandom_range(99) < 28) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, idx, sample};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_result(op, sample, idx);
    pending_results.insert(pending_results.size(), predicted);
    items_sent++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_edge(input int idx, input logic [EDGE_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(idx * 4);
    cfg_pwdata  <= {16'h0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    edge_model[idx] = value;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_edges(input edge_arr_t e);
    int i;
    wait_idle();
    for (i = 0; i < NUM_EDGES; i++) write_edge(i, e[i]);
    edge_settings++;
  endtask

  function automatic edge_arr_t random_edges(int lo, int hi, bit sorted);
    int        v [NUM_EDGES];
    int        i;
    int        j;
    int        t;
    edge_arr_t e;
    for (i = 0; i < NUM_EDGES; i++) v[i] = lo + int'($urandom_range(hi - lo));
    if (sorted)
      for (i = 1; i < NUM_EDGES; i++)
        for (j = i; j > 0 && v[j-1] > v[j]; j--) begin
          t = v[j]; v[j] = v[j-1]; v[j-1] = t;
        end
    for (i = 0; i < NUM_EDGES; i++) e[i] = v[i][EDGE_W-1:0];
    return e;
  endfunction

  function automatic logic [EDGE_W-1:0] pick_sample();
    int e;
    e = 0;
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3, 4, 5: begin
        // land on or right beside an edge
        e = int'(edge_model[$urandom_range(NUM_EDGES - 1)]) + int'($urandom_range(4)) - 2;
        return e[EDGE_W-1:0];
      end
      default: return EDGE_W'($urandom());
    endcase
  endfunction

  task automatic send_random(input int n);
    int k;
    int r;
    op_t op;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 60)      op = OP_COUNT;
      else if (r < 75) op = OP_READ;
      else if (r < 97) op = OP_RANGE;
      else             op = OP_CLEAR;
      send_item(op, pick_sample(), IDX_W'($urandom()));
    end
  endtask

  task automatic test_reset_state();
    send_item(OP_RANGE, 16'h0000, 3'd0);
    send_item(OP_READ,  16'h0000, 3'd7);
    send_item(OP_COUNT, 16'h7FFF, 3'd0);
    send_item(OP_COUNT, 16'h8000, 3'd7);
    send_item(OP_READ,  16'hFFFF, 3'd0);
    send_item(OP_RANGE, 16'h0000, 3'd0);
    send_item(OP_CLEAR, 16'h1234, 3'd5);
    send_item(OP_RANGE, 16'h0000, 3'd0);
  endtask

  task automatic test_edge_cases();
    edge_arr_t e;
    // equal edges, one edge below its neighbor, top edge below full scale
    e[0] = 16'h8000; e[1] = 16'hFF00; e[2] = 16'h0000; e[3] = 16'h0000;
    e[4] = 16'h0100; e[5] = 16'h0064; e[6] = 16'h7FFE; e[7] = 16'h7FFE;
    program_edges(e);
    send_item(OP_COUNT, 16'h8000, 3'd0);
    send_item(OP_COUNT, 16'h8001, 3'd0);
    send_item(OP_COUNT, 16'h0000, 3'd0);
    send_item(OP_COUNT, 16'h0001, 3'd0);
    send_item(OP_COUNT, 16'h0065, 3'd0);
    send_item(OP_COUNT, 16'h012C, 3'd0);
    send_item(OP_COUNT, 16'h7FFF, 3'd0);
    send_item(OP_READ,  16'h0000, 3'd3);
    send_item(OP_READ,  16'h0000, 3'd5);
    send_item(OP_RANGE, 16'h0000, 3'd0);
    send_item(OP_CLEAR, 16'h0000, 3'd0);
    send_item(OP_RANGE, 16'h0000, 3'd0);
  endtask

  task automatic test_random_ordered();
    program_edges(random_edges(-32768, 32767, 1'b1));
    send_random(220);
    program_edges(random_edges(-2048, 2048, 1'b1));
    send_random(220);
    program_edges(random_edges(-20, 20, 1'b1));
    send_random(150);
  endtask

  task automatic test_random_extreme_edges();
    edge_arr_t e;
    e = {NUM_EDGES{16'h8000}};
    program_edges(e);
    send_random(100);
    e = {NUM_EDGES{16'h7FFF}};
    program_edges(e);
    send_random(100);
    program_edges(random_edges(-32768, 32767, 1'b0));
    send_random(150);
  endtask

  task automatic test_no_idle();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    program_edges(random_edges(-4096, 4096, 1'b1));
    send_random(200);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    program_edges(random_edges(-1024, 1024, 1'b1));
    src_idle_on = 1'b0;
    hold_req_cnt++;
    send_random(60);
    src_idle_on = 1'b1;
    // pause until every result is back, then carry on
    wait_idle();
    send_random(60);
  endtask

  // back-to-back counts into one bin exercise the forwarding path
  task automatic test_count_burst();
    int  k;
    edge_arr_t e;
    e = {NUM_EDGES{16'h7FFF}};
    program_edges(e);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_item(OP_CLEAR, 16'h0000, 3'd0);
    for (k = 0; k < BURST_LEN; k++)
      send_item(OP_COUNT, EDGE_W'($urandom()), 3'd0);
    send_item(OP_READ,  16'h0000, 3'd0);
    send_item(OP_RANGE, 16'h0000, 3'd0);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      if (fail_count < MAX_REPORTS)
        $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      chk_got = result_t'(out_tdata[30:0]);
      if (pending_results.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $error("result transfer with nothing expected: tdata %h", out_tdata);
        fail_count++;
      end else begin
        chk_want = pending_results.pop_front();
        check_field("bin",            chk_want.bin,            chk_got.bin);
        check_field("count",          chk_want.count,          chk_got.count);
        check_field("first_occupied", chk_want.first_occupied, chk_got.first_occupied);
        check_field("last_occupied",  chk_want.last_occupied,  chk_got.last_occupied);
        check_field("all_empty",      chk_want.all_empty,      chk_got.all_empty);
        check_field("tdata pad",      0,                       out_tdata[31]);
      end
      results_seen++;
    end
  end

  // result sink: random idling plus a requested long hold-off
  always @(posedge clk) begin
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt = hold_req_cnt;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (sink_idle_on && $urandom_range(99) < 28) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog: no transfer while work is outstanding
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel ||
        (pending_results.size() == 0 && !in_tvalid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d results still outstanding", pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < NUM_EDGES; i++) edge_model[i] = EDGE_RESET;
    for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_edge_cases();
    test_random_ordered();
    test_random_extreme_edges();
    test_no_idle();
    test_backpressure();
    test_count_burst();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input transfers, %0d results, %0d edge settings",
             items_sent, results_seen, edge_settings);
    $display("incl. corner edges, single-bin burst, output hold-off and drain pause");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
